FILE: hdl/tvwc_pkg.sv
// tvwc_pkg: shared constants, the front-to-back item type and the
// code point helpers of the terminal visual width counter.
// No dependencies.
package tvwc_pkg;

    localparam int TVWC_COUNT_BITS  = 16;
    localparam int TVWC_QUEUE_DEPTH = 2;
    localparam int TVWC_CP_BITS     = 21;
    localparam int TVWC_OUT_BITS    = 16;

    localparam logic [7:0] ESC_BYTE = 8'h1B;
    localparam logic [7:0] END_BYTE = 8'h6D;
    localparam logic [TVWC_OUT_BITS-1:0] OUT_MAX = 16'hFFFF;

    // sequence length codes a lead byte can announce
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_TWO  = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR = 3'd4;

    typedef logic [TVWC_CP_BITS-1:0] tvwc_cp_t;

    // one classified beat from the front to the back
    typedef struct packed {
        logic       has_cp;   // a code point completed on this byte
        tvwc_cp_t   cp;
        logic       last;     // end of string, emit the total
        logic [1:0] flush_w;  // columns of the cut-short tail
    } tvwc_item_t;

    function automatic logic [2:0] lead_len(input logic [7:0] c);
        logic [2:0] len;
        len = SEQ_NONE;
        if (c[7:5] == 3'b110)
        begin
            len = SEQ_TWO;
        end
        else if (c[7:4] == 4'b1110)
        begin
            len = SEQ_THREE;
        end
        else if (c[7:3] == 5'b11110)
        begin
            len = SEQ_FOUR;
        end
        return len;
    endfunction

    function automatic logic [1:0] cp_width(input tvwc_cp_t r);
        logic [1:0] w;
        w = 2'd1;
        if (r == 21'h200D || r == 21'h200C || (r >= 21'hFE00 && r <= 21'hFE0F))
        begin
            w = 2'd0;
        end
        else if (r >= 21'h0300 && r <= 21'h036F)
        begin
            w = 2'd0;
        end
        else if ((r >= 21'h1F000 && r <= 21'h1FAFF) || (r >= 21'h2600 && r <= 21'h27BF) ||
                 (r >= 21'h2E80 && r <= 21'h2FDF) || (r >= 21'h3000 && r <= 21'h9FFF) ||
                 (r >= 21'hF900 && r <= 21'hFAFF) || (r >= 21'hFF01 && r <= 21'hFF60) ||
                 (r >= 21'hFFE0 && r <= 21'hFFE6))
        begin
            w = 2'd2;
        end
        return w;
    endfunction

endpackage

FILE: hdl/tvwc_ifs.sv
// Valid/ready channel interfaces for the byte input and width output.
// No dependencies.
interface tvwc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface tvwc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] visual_width;

    modport source (output valid, output visual_width, input ready);
    modport sink (input valid, input visual_width, output ready);
endinterface

FILE: hdl/tvwc_front.sv
// tvwc_front: escape filter and UTF-8 sequence assembly; pushes one
// classified item per completed code point or end of string.
// Depends on tvwc_pkg and tvwc_ifs.
module tvwc_front
    import tvwc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tvwc_in_if.sink      byte_in,
    input  logic         q_full,
    output logic         push,
    output tvwc_item_t   item
);

    logic       esc_reg, esc_next;
    logic [7:0] pend_reg [3];
    logic [7:0] pend_next [3];
    logic [1:0] pcnt_reg, pcnt_next;
    logic [2:0] slen_reg, slen_next;

    logic       accept;
    logic [7:0] b;
    logic [2:0] len;
    logic       cp_done;
    tvwc_cp_t   cp_val;
    logic [1:0] flush_w;

    assign byte_in.ready = !q_full;
    assign accept = byte_in.valid && byte_in.ready;
    assign b = byte_in.byte_value;
    assign len = lead_len(b);

    always_comb
    begin
        esc_next  = esc_reg;
        pend_next = pend_reg;
        pcnt_next = pcnt_reg;
        slen_next = slen_reg;
        cp_done   = 1'b0;
        cp_val    = '0;
        flush_w   = 2'd0;
        if (accept)
        begin
            if (b == ESC_BYTE)
            begin
                esc_next = 1'b1;
            end
            else if (esc_reg)
            begin
                if (b == END_BYTE)
                begin
                    esc_next = 1'b0;
                end
            end
            else if (pcnt_reg == 2'd0)
            begin
                if (len == SEQ_NONE)
                begin
                    cp_done = 1'b1;
                    cp_val  = TVWC_CP_BITS'(b);
                end
                else
                begin
                    pend_next[0] = b;
                    pcnt_next    = 2'd1;
                    slen_next    = len;
                end
            end
            else if (({1'b0, pcnt_reg} + 3'd1) == slen_reg)
            begin
                cp_done   = 1'b1;
                pcnt_next = 2'd0;
                slen_next = SEQ_NONE;
                case (slen_reg)
                    SEQ_TWO:   cp_val = TVWC_CP_BITS'({pend_reg[0][4:0], b[5:0]});
                    SEQ_THREE: cp_val = TVWC_CP_BITS'({pend_reg[0][3:0], pend_reg[1][5:0],
                                                       b[5:0]});
                    default:   cp_val = {pend_reg[0][2:0], pend_reg[1][5:0],
                                         pend_reg[2][5:0], b[5:0]};
                endcase
            end
            else
            begin
                case (pcnt_reg)
                    2'd1:    pend_next[1] = b;
                    2'd2:    pend_next[2] = b;
                    default: ;
                endcase
                pcnt_next = pcnt_reg + 2'd1;
            end

            // cut-short tail: lead counts 1, the rest is decoded again
            case (pcnt_next)
                2'd0: flush_w = 2'd0;
                2'd1: flush_w = 2'd1;
                2'd2: flush_w = 2'd2;
                default:
                begin
                    if (lead_len(pend_next[1]) == SEQ_TWO)
                    begin
                        flush_w = 2'd1 + cp_width(TVWC_CP_BITS'({pend_next[1][4:0],
                                                                 pend_next[2][5:0]}));
                    end
                    else
                    begin
                        flush_w = 2'd3;
                    end
                end
            endcase

            if (byte_in.last_byte)
            begin
                esc_next  = 1'b0;
                pcnt_next = 2'd0;
                slen_next = SEQ_NONE;
            end
        end
    end

    assign push = accept && (cp_done || byte_in.last_byte);
    assign item.has_cp  = cp_done;
    assign item.cp      = cp_val;
    assign item.last    = byte_in.last_byte;
    assign item.flush_w = byte_in.last_byte ? flush_w : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg  <= 1'b0;
            pcnt_reg <= 2'd0;
            slen_reg <= SEQ_NONE;
        end
        else
        begin
            esc_reg  <= esc_next;
            pcnt_reg <= pcnt_next;
            slen_reg <= slen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

FILE: hdl/tvwc_queue.sv
// tvwc_queue: short register FIFO of classified items between the
// front and back parts. Depends on tvwc_pkg.
module tvwc_queue
    import tvwc_pkg::*;
#(
    parameter int DEPTH = TVWC_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  tvwc_item_t push_item,
    input  logic       pop,
    output tvwc_item_t head,
    output logic       not_empty,
    output logic       full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tvwc_item_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

FILE: hdl/tvwc_back.sv
// tvwc_back: column lookup, saturating accumulation and the output
// register of the total. Depends on tvwc_pkg and tvwc_ifs.
module tvwc_back
    import tvwc_pkg::*;
#(
    parameter int COUNT_BITS = TVWC_COUNT_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  tvwc_item_t   head,
    output logic         pop,
    tvwc_out_if.source   width_out
);

    localparam int WB = (COUNT_BITS > TVWC_OUT_BITS) ? COUNT_BITS : TVWC_OUT_BITS + 1;

    logic [COUNT_BITS-1:0]    total_reg, total_next;
    logic [TVWC_OUT_BITS-1:0] width_reg, width_next;
    logic                     vld_reg, vld_next;

    logic [2:0]            add_w;
    logic [COUNT_BITS:0]   sum;
    logic [COUNT_BITS-1:0] sat_total;
    logic [WB-1:0]         ext_total;

    assign add_w = (head.has_cp ? {1'b0, cp_width(head.cp)} : 3'd0) + {1'b0, head.flush_w};
    assign sum   = {1'b0, total_reg} + (COUNT_BITS + 1)'(add_w);
    assign sat_total = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
    assign ext_total = WB'(sat_total);

    // end-of-string beats wait for the output register to free up
    assign pop = q_valid && (!head.last || !vld_reg || width_out.ready);

    always_comb
    begin
        total_next = total_reg;
        width_next = width_reg;
        vld_next   = vld_reg;
        if (vld_reg && width_out.ready)
        begin
            vld_next = 1'b0;
        end
        if (pop)
        begin
            if (head.last)
            begin
                total_next = '0;
                vld_next   = 1'b1;
                width_next = (ext_total > WB'(OUT_MAX)) ? OUT_MAX
                                                         : ext_total[TVWC_OUT_BITS-1:0];
            end
            else
            begin
                total_next = sat_total;
            end
        end
    end

    assign width_out.valid        = vld_reg;
    assign width_out.visual_width = width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            total_reg <= total_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg <= width_next;
    end

endmodule

FILE: hdl/terminal_visual_width_counter_unit.sv
// Terminal visual width counter: takes a string one byte per beat and
// returns its display column count after the byte marked last. ESC..'m'
// runs are dropped, UTF-8 is decoded by lead-byte mask and each code
// point adds 0, 1 or 2 columns; the total saturates. The block takes one
// byte per clock while the item queue has room; the total passes through
// the item queue into the output register once it is free. A two-entry
// item queue decouples the byte front end from the accumulator, and the
// output register lets the next string stream in while a total waits;
// input ready drops only when that queue is full.
// Depends on tvwc_pkg, tvwc_ifs, tvwc_front, tvwc_queue and tvwc_back.
module terminal_visual_width_counter_unit
    import tvwc_pkg::*;
#(
    parameter int COUNT_BITS  = TVWC_COUNT_BITS,
    parameter int QUEUE_DEPTH = TVWC_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    tvwc_in_if.sink    byte_in,
    tvwc_out_if.source width_out
);

    logic       push, pop, q_full, q_valid;
    tvwc_item_t push_item, head;

    tvwc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .q_full  (q_full),
        .push    (push),
        .item    (push_item)
    );

    tvwc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .not_empty (q_valid),
        .full      (q_full)
    );

    tvwc_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .width_out (width_out)
    );

endmodule

FILE: hdl/tvwc_chk.sv
// tvwc_chk: port-level checks of the width counter, bound to the top.
// Depends on terminal_visual_width_counter_unit.
module tvwc_chk #(
    parameter int MAX_OPEN = 3
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_width
);

    localparam int OW = $clog2(MAX_OPEN + 2);

    logic [OW-1:0] open_reg;
    logic          in_end, out_beat;

    assign in_end   = in_valid && in_ready && in_last;
    assign out_beat = out_valid && out_ready;

    // strings accepted whose total has not been delivered yet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else if (in_end && !out_beat)
        begin
            open_reg <= open_reg + 1'b1;
        end
        else if (out_beat && !in_end)
        begin
            open_reg <= open_reg - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_width))
        else $error("total dropped or changed while stalled");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> open_reg != '0)
        else $error("total delivered without an ended string");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg <= OW'(MAX_OPEN))
        else $error("more strings in flight than the queue can hold");

endmodule

bind terminal_visual_width_counter_unit tvwc_chk #(
    .MAX_OPEN (QUEUE_DEPTH + 1)
) u_tvwc_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (byte_in.valid),
    .in_ready  (byte_in.ready),
    .in_last   (byte_in.last_byte),
    .out_valid (width_out.valid),
    .out_ready (width_out.ready),
    .out_width (width_out.visual_width)
);

FILE: tb/tvwc_width_check_pkg.sv
// Column predictor and total checker for the terminal width counter bench.
// Depends on tvwc_pkg for the escape bytes, sequence codes and widths.
package tvwc_width_check_pkg;
    import tvwc_pkg::*;

    class column_checker;
        bit                       in_escape;
        bit [7:0]                 held [3];
        bit [1:0]                 held_cnt;
        bit [2:0]                 seq_len;
        bit [TVWC_COUNT_BITS-1:0] columns;
        bit [TVWC_OUT_BITS-1:0]   pending_totals [$];
        int unsigned              mismatches;
        int unsigned              totals_seen;

        function new();
            clear();
            mismatches  = 0;
            totals_seen = 0;
        endfunction

        function void clear();
            in_escape = 1'b0;
            held_cnt  = '0;
            seq_len   = '0;
            columns   = '0;
        endfunction

        task report(input string msg);
            if (mismatches < 30)
            begin
                $display("MISMATCH: %s", msg);
            end
            mismatches++;
        endtask

        function bit [1:0] col_width(input bit [20:0] cp);
            if (cp == 21'h200C || cp == 21'h200D || (cp >= 21'hFE00 && cp <= 21'hFE0F) ||
                (cp >= 21'h0300 && cp <= 21'h036F))
            begin
                return 2'd0;
            end
            if ((cp >= 21'h1F000 && cp <= 21'h1FAFF) || (cp >= 21'h2600 && cp <= 21'h27BF) ||
                (cp >= 21'h2E80 && cp <= 21'h2FDF) || (cp >= 21'h3000 && cp <= 21'h9FFF) ||
                (cp >= 21'hF900 && cp <= 21'hFAFF) || (cp >= 21'hFF01 && cp <= 21'hFF60) ||
                (cp >= 21'hFFE0 && cp <= 21'hFFE6))
            begin
                return 2'd2;
            end
            return 2'd1;
        endfunction

        function bit [2:0] seq_for_lead(input bit [7:0] b);
            casez (b)
                8'b110?????: return SEQ_TWO;
                8'b1110????: return SEQ_THREE;
                8'b11110???: return SEQ_FOUR;
                default:     return SEQ_NONE;
            endcase
        endfunction

        function bit [20:0] assemble(input bit [7:0] b0, input bit [7:0] b1,
                                     input bit [7:0] b2, input bit [7:0] b3,
                                     input bit [2:0] len);
            case (len)
                SEQ_TWO:   return {10'd0, b0[4:0], b1[5:0]};
                SEQ_THREE: return {5'd0, b0[3:0], b1[5:0], b2[5:0]};
                default:   return {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            endcase
        endfunction

        function void add_cols(input bit [1:0] w);
            longint sum;
            longint col_max;
            col_max = (longint'(1) << TVWC_COUNT_BITS) - 1;
            sum     = longint'(columns) + w;
            columns = TVWC_COUNT_BITS'((sum > col_max) ? col_max : sum);
        endfunction

        function bit [7:0] held_at(input int i);
            return (i < 3) ? held[i] : 8'h00;
        endfunction

        // tail of a string that ended mid-sequence: re-decode what is held
        function void drain_held();
            int       i;
            bit [2:0] len;
            i = 0;
            while (i < held_cnt)
            begin
                len = seq_for_lead(held[i]);
                if (len != SEQ_NONE && i + len <= held_cnt)
                begin
                    add_cols(col_width(assemble(held_at(i), held_at(i + 1), held_at(i + 2),
                                                8'h00, len)));
                    i += len;
                end
                else
                begin
                    add_cols(col_width({13'd0, held[i]}));
                    i++;
                end
            end
            held_cnt = '0;
            seq_len  = '0;
        endfunction

        function void take_kept(input bit [7:0] b);
            bit [7:0] s [4];
            bit [2:0] len;
            if (held_cnt == 0)
            begin
                len = seq_for_lead(b);
                if (len == SEQ_NONE)
                begin
                    add_cols(col_width({13'd0, b}));
                end
                else
                begin
                    held[0]  = b;
                    held_cnt = 2'd1;
                    seq_len  = len;
                end
            end
            else if (held_cnt + 1 == seq_len)
            begin
                s[0]        = held[0];
                s[1]        = held[1];
                s[2]        = held[2];
                s[3]        = 8'h00;
                s[held_cnt] = b;
                add_cols(col_width(assemble(s[0], s[1], s[2], s[3], seq_len)));
                held_cnt = '0;
                seq_len  = '0;
            end
            else
            begin
                held[held_cnt] = b;
                held_cnt++;
            end
        endfunction

        // one accepted input beat
        function void take_byte(input bit [7:0] b, input bit lst);
            bit [TVWC_OUT_BITS-1:0] t;
            if (b == ESC_BYTE)
            begin
                in_escape = 1'b1;
            end
            else if (in_escape)
            begin
                if (b == END_BYTE)
                begin
                    in_escape = 1'b0;
                end
            end
            else
            begin
                take_kept(b);
            end
            if (lst)
            begin
                drain_held();
                t = (columns > OUT_MAX) ? OUT_MAX : TVWC_OUT_BITS'(columns);
                pending_totals = {pending_totals, t};
                clear();
            end
        endfunction

        // one accepted output beat
        task check_total(input logic [TVWC_OUT_BITS-1:0] got);
            bit [TVWC_OUT_BITS-1:0] want;
            totals_seen++;
            if (pending_totals.size() == 0)
            begin
                report($sformatf("width %0d arrived with no string pending", got));
            end
            else
            begin
                want = pending_totals.pop_front();
                if (got !== want)
                begin
                    report($sformatf("total %0d: width %0d, predicted %0d",
                                     totals_seen, got, want));
                end
            end
        endtask

        task close_out();
            if (pending_totals.size() != 0)
            begin
                report($sformatf("%0d predicted widths never arrived", pending_totals.size()));
            end
        endtask
    endclass

endpackage

FILE: tb/tb.sv
// Top-level bench for terminal_visual_width_counter_unit: drives byte strings,
// stalls both sides and checks each width against column_checker.
// Depends on tvwc_pkg, tvwc_ifs and tvwc_width_check_pkg.
module tb;
    import tvwc_pkg::*;
    import tvwc_width_check_pkg::*;

    localparam int HOLD_CYCLES = 64;
    localparam int IDLE_LIMIT  = 4000;
    localparam int TAIL_CYCLES = 8;

    logic clk;
    logic rst_n;

    tvwc_in_if  byte_in ();
    tvwc_out_if width_out ();

    terminal_visual_width_counter_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .width_out (width_out)
    );

    column_checker col_chk;
    logic [7:0]    line_q [$];
    int unsigned   send_idle_pct = 0;
    int unsigned   stall_pct     = 0;
    logic          hold_req      = 1'b0;
    int unsigned   bytes_in      = 0;
    int unsigned   bytes_sent    = 0;
    int unsigned   strings_sent  = 0;
    int unsigned   idle_run      = 0;

    // code points at the borders of the zero and double width ranges
    int unsigned wide_bounds [32] = '{
        'h200B, 'h200C, 'h200D, 'h200E, 'h25FF, 'h2600, 'h27BF, 'h27C0,
        'h2E7F, 'h2E80, 'h2FDF, 'h2FE0, 'h2FFF, 'h3000, 'h9FFF, 'hA000,
        'hF8FF, 'hF900, 'hFAFF, 'hFB00, 'hFE00, 'hFE0F, 'hFE10, 'hFF00,
        'hFF01, 'hFF60, 'hFF61, 'hFFDF, 'hFFE0, 'hFFE6, 'hFFE7, 'hFFFF
    };
    int unsigned wide4_bounds [4] = '{'h1EFFF, 'h1F000, 'h1FAFF, 'h1FB00};
    int unsigned narrow_bounds [4] = '{'h02FF, 'h0300, 'h036F, 'h0370};

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------- byte sender ----------------

    task automatic send_byte(input logic [7:0] b, input logic lst);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            byte_in.valid <= 1'b0;
            @(posedge clk);
        end
        byte_in.valid      <= 1'b1;
        byte_in.byte_value <= b;
        byte_in.last_byte  <= lst;
        @(posedge clk);
        while (!byte_in.ready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic send_line();
        int i;
        for (i = 0; i < line_q.size(); i++)
        begin
            send_byte(line_q[i], i == line_q.size() - 1);
        end
        strings_sent++;
    endtask

    task automatic wait_drained();
        byte_in.valid <= 1'b0;
        while (col_chk.pending_totals.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ---------------- string builders ----------------

    function automatic void put_byte(input logic [7:0] b);
        line_q = {line_q, b};
    endfunction

    function automatic logic [7:0] cont_byte(input logic [20:0] v);
        logic [1:0] top;
        // continuation bytes are not checked, so the marker bits are sometimes junk
        top = ($urandom_range(7, 0) == 0) ? 2'($urandom_range(3, 0)) : 2'b10;
        return {top, v[5:0]};
    endfunction

    function automatic void push_escape(input bit closed);
        int unsigned n;
        n = $urandom_range(4, 0);
        put_byte(ESC_BYTE);
        repeat (n)
        begin
            put_byte(($urandom_range(3, 0) == 0) ? 8'($urandom_range(255, 0))
                                                 : 8'($urandom_range(8'h3F, 8'h30)));
        end
        if (closed)
        begin
            put_byte(END_BYTE);
        end
    endfunction

    function automatic void push_cp(input logic [20:0] cp, input logic [2:0] len,
                                    input bit split);
        int k;
        case (len)
            SEQ_TWO:   put_byte({3'b110, cp[10:6]});
            SEQ_THREE: put_byte({4'b1110, cp[15:12]});
            default:   put_byte({5'b11110, cp[20:18]});
        endcase
        if (split)
        begin
            push_escape(1'b1);
        end
        for (k = int'(len) - 2; k >= 0; k--)
        begin
            put_byte(cont_byte(cp >> (6 * k)));
        end
    endfunction

    // lead byte followed by too few continuations
    function automatic void push_broken();
        int unsigned len;
        int unsigned n;
        len = $urandom_range(4, 2);
        case (len)
            2:       put_byte({3'b110, 5'($urandom_range(31, 0))});
            3:       put_byte({4'b1110, 4'($urandom_range(15, 0))});
            default: put_byte({5'b11110, 3'($urandom_range(7, 0))});
        endcase
        n = $urandom_range(len - 2, 0);
        repeat (n)
        begin
            put_byte(8'($urandom_range(8'hBF, 8'h80)));
        end
    endfunction

    function automatic void push_char();
        int unsigned pick;
        logic [20:0] cp;
        logic [7:0]  b;
        pick = $urandom_range(99, 0);
        if (pick < 28)
        begin
            b = 8'($urandom_range(127, 0));
            if (b == ESC_BYTE)
            begin
                b = 8'h7E;
            end
            put_byte(b);
        end
        else if (pick < 44)
        begin
            cp = $urandom_range(1, 0) ? 21'(wide_bounds[$urandom_range(31, 0)])
                                      : 21'($urandom_range(16'hFFFF, 0));
            push_cp(cp, SEQ_THREE, 1'b0);
        end
        else if (pick < 54)
        begin
            case ($urandom_range(2, 0))
                0:       cp = 21'(wide4_bounds[$urandom_range(3, 0)]);
                1:       cp = 21'($urandom_range(21'h1FAFF, 21'h1F000));
                default: cp = 21'($urandom_range(21'h1FFFFF, 0));
            endcase
            push_cp(cp, SEQ_FOUR, 1'b0);
        end
        else if (pick < 62)
        begin
            cp = $urandom_range(1, 0) ? 21'(narrow_bounds[$urandom_range(3, 0)])
                                      : 21'($urandom_range(11'h7FF, 0));
            push_cp(cp, SEQ_TWO, 1'b0);
        end
        else if (pick < 70)
        begin
            push_escape(1'b1);
        end
        else if (pick < 77)
        begin
            push_cp(21'(wide_bounds[$urandom_range(31, 0)]), SEQ_THREE, 1'b1);
        end
        else if (pick < 85)
        begin
            put_byte($urandom_range(1, 0) ? 8'($urandom_range(8'hBF, 8'h80))
                                          : 8'($urandom_range(8'hFF, 8'hF8)));
        end
        else if (pick < 93)
        begin
            push_broken();
        end
        else
        begin
            put_byte(8'($urandom_range(255, 0)));
        end
    endfunction

    function automatic void build_line();
        int unsigned n;
        int unsigned ending;
        line_q.delete();
        n = $urandom_range(8, 1);
        repeat (n)
        begin
            push_char();
        end
        ending = $urandom_range(99, 0);
        if (ending < 12)
        begin
            push_broken();
        end
        else if (ending < 20)
        begin
            push_escape(1'b0);
        end
    endfunction

    task automatic run_random(input int unsigned target);
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < target)
        begin
            build_line();
            send_line();
        end
    endtask

    // ---------------- result receiver ----------------

    initial
    begin
        bit hold_taken;
        hold_taken = 1'b0;
        width_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                width_out.ready <= 1'b0;
                hold_taken = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                width_out.ready <= (stall_pct == 0) || ($urandom_range(99, 0) >= stall_pct);
            end
        end
    end

    // ---------------- monitor and watchdog ----------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_in.valid && byte_in.ready)
            begin
                col_chk.take_byte(byte_in.byte_value, byte_in.last_byte);
                bytes_in++;
            end
            if (width_out.valid && width_out.ready)
            begin
                col_chk.check_total(width_out.visual_width);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((byte_in.valid && byte_in.ready) || (width_out.valid && width_out.ready))
        begin
            idle_run <= 0;
        end
        else if (idle_run >= IDLE_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
        else
        begin
            idle_run <= idle_run + 1;
        end
    end

    // ---------------- main sequence ----------------

    initial
    begin
        int ph;
        int i;
        col_chk = new();
        rst_n   = 1'b0;
        byte_in.valid      <= 1'b0;
        byte_in.byte_value <= 8'h00;
        byte_in.last_byte  <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed strings
        line_q = '{8'h41};                         send_line();
        line_q = '{8'h00};                         send_line();
        line_q = '{8'hFF};                         send_line();
        line_q = '{8'h80};                         send_line();
        line_q = '{8'hE4, 8'hB8, 8'h80};           send_line();
        line_q = '{8'hF0, 8'h9F, 8'h98, 8'h80};    send_line();
        line_q = '{8'hE2, 8'h80, 8'h8D};           send_line();
        line_q = '{8'hCC, 8'h80};                  send_line();
        // escape dropped in the middle of a CJK char
        line_q = '{8'hE4, ESC_BYTE, END_BYTE, 8'hB8, 8'h80};
        send_line();
        // string cut after two bytes of a three byte char
        line_q = '{8'hE4, 8'hB8};                  send_line();
        // string ends inside an escape
        line_q = '{8'h41, ESC_BYTE, 8'h5B};        send_line();

        // output held off while one-byte strings keep coming
        hold_req <= 1'b1;
        for (i = 0; i < 16; i++)
        begin
            line_q = '{8'($urandom_range(126, 32))};
            send_line();
        end
        wait_drained();

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                end
                1:
                begin
                    send_idle_pct = 48;
                    stall_pct    <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 48;
                end
                default:
                begin
                    send_idle_pct = 9;
                    stall_pct    <= 9;
                end
            endcase
            run_random(120);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        col_chk.close_out();
        $display("Run: %0d bytes in %0d strings, %0d widths checked, over four stall mixes",
                 bytes_in, strings_sent, col_chk.totals_seen);
        $display("incl. split and cut-short UTF-8, junk continuations, open escapes, hold-off");
        if (col_chk.mismatches == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/tvwc_pkg.sv
hdl/tvwc_ifs.sv
hdl/tvwc_front.sv
hdl/tvwc_queue.sv
hdl/tvwc_back.sv
hdl/terminal_visual_width_counter_unit.sv
hdl/tvwc_chk.sv
tb/tvwc_width_check_pkg.sv
tb/tb.sv
